>>> hw/rtl/serial_frame_receiver_checksum_assert.svh
// Assertion macros for the serial frame receiver.
`ifndef SERIAL_FRAME_RECEIVER_CHECKSUM_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_CHECKSUM_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SFRC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sfrc: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define SFRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sfrc: next-cycle check failed");

`endif

>>> hw/rtl/sfrc_pkg.sv
// Shared types and constants for the serial frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package sfrc_pkg;

	localparam int BYTE_W = 8;
	localparam int WORD_W = 16;
	localparam int MAX_FRAME_DEF = 32;

	typedef logic [1:0] frame_status_t;

	localparam frame_status_t ST_OK        = 2'd0;
	localparam frame_status_t ST_BAD_SUM   = 2'd1;
	localparam frame_status_t ST_TOO_LONG  = 2'd2;
	localparam frame_status_t ST_TOO_SHORT = 2'd3;

	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hE1;

	typedef struct packed {
		frame_status_t       status;
		logic [BYTE_W-1:0]   address;
		logic [BYTE_W-1:0]   command;
		logic [WORD_W-1:0]   data_word;
		logic [BYTE_W-1:0]   count;
	} frame_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/sfrc_parser.sv
// Frame parser: hunt/count/sum state and the result of one byte.
`timescale 1ns / 1ps
`default_nettype none

module sfrc_parser import sfrc_pkg::*; #(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic [BYTE_W-1:0] start_byte,
	output logic                   res_valid,
	output frame_result_t          res
);

	localparam int IDX_W = $clog2(MAX_FRAME);
	localparam logic [BYTE_W-1:0] MAX_B = BYTE_W'(MAX_FRAME);

	logic              in_frame_q, in_frame_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [BYTE_W-1:0] count_q, count_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0] addr_q, addr_d;
	logic [BYTE_W-1:0] cmd_q, cmd_d;
	logic [WORD_W-1:0] data_q, data_d;
	logic [BYTE_W-1:0] idx_ext;

	assign idx_ext = BYTE_W'(idx_q);

	always_comb begin
		in_frame_d = in_frame_q;
		idx_d      = idx_q;
		count_d    = count_q;
		sum_d      = sum_q;
		addr_d     = addr_q;
		cmd_d      = cmd_q;
		data_d     = data_q;
		res_valid  = 1'b0;
		res        = '{status: ST_OK, address: addr_q, command: cmd_q,
		               data_word: data_q, count: count_q};

		if (!in_frame_q) begin
			if (rx_byte == start_byte) begin
				in_frame_d = 1'b1;
				idx_d      = IDX_W'(1);
				count_d    = '0;
				sum_d      = '0;
				addr_d     = '0;
				cmd_d      = '0;
				data_d     = '0;
			end
		end else if (idx_ext == 8'd1) begin
			count_d = rx_byte;
			if (rx_byte >= MAX_B) begin
				res_valid  = 1'b1;
				res        = '{status: ST_TOO_LONG, address: '0, command: '0,
				               data_word: '0, count: rx_byte};
				in_frame_d = 1'b0;
				idx_d      = '0;
				count_d    = '0;
			end else begin
				sum_d = sum_q + rx_byte;
				idx_d = IDX_W'(2);
			end
		end else if (idx_ext < count_q) begin
			sum_d = sum_q + rx_byte;
			if (idx_ext == 8'd2) addr_d = rx_byte;
			if (idx_ext == 8'd3) cmd_d = rx_byte;
			if (idx_ext == 8'd4) data_d = {rx_byte, data_q[BYTE_W-1:0]};
			if (idx_ext == 8'd5) data_d = {data_q[WORD_W-1:BYTE_W], rx_byte};
			idx_d = idx_q + IDX_W'(1);
		end else begin
			// checksum byte, or the dropped byte after a too-short count
			res_valid = 1'b1;
			if (idx_ext == count_q) begin
				res.status = (rx_byte == ~sum_q) ? ST_OK : ST_BAD_SUM;
			end else begin
				res = '{status: ST_TOO_SHORT, address: '0, command: '0,
				       data_word: '0, count: count_q};
			end
			in_frame_d = 1'b0;
			idx_d      = '0;
			count_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			idx_q      <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			addr_q     <= '0;
			cmd_q      <= '0;
			data_q     <= '0;
		end else if (step) begin
			in_frame_q <= in_frame_d;
			idx_q      <= idx_d;
			count_q    <= count_d;
			sum_q      <= sum_d;
			addr_q     <= addr_d;
			cmd_q      <= cmd_d;
			data_q     <= data_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/serial_frame_receiver_checksum.sv
// Top level: length-prefixed serial frame receiver with inverted-sum checksum.
// Flow: an accepted word is registered in the input stage and parsed once the
//   result slot is free; that parse step also loads its result, if any.
// Throughput: one received byte per cycle while the result slot is free or emptied.
// Reset (arst_n low, asynchronous): hunting for the start byte, no words held,
//   start byte register back to 0xE1.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_frame_receiver_checksum_assert.svh"

module serial_frame_receiver_checksum import sfrc_pkg::*; #(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration: start byte
	input  wire logic              cfg_wr_en,
	input  wire logic [BYTE_W-1:0] cfg_wr_data,
	// input channel
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] rx_byte,
	// output channel
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             frame_status,
	output logic [BYTE_W-1:0]      frame_address,
	output logic [BYTE_W-1:0]      frame_command,
	output logic [WORD_W-1:0]      frame_data_word,
	output logic [BYTE_W-1:0]      frame_count
);

	logic [BYTE_W-1:0] start_byte_q;

	// input stage
	logic              byte_valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// result register
	logic              out_valid_q;
	frame_result_t     out_q;

	logic              advance;   // result slot free, or being emptied this cycle
	logic              step;      // parse the word held in the input stage
	logic              res_valid;
	frame_result_t     res;

	assign advance  = !out_valid_q || out_ready;
	assign step     = byte_valid_s1 && advance;
	// input stage is free if empty or its word moves on this cycle
	assign in_ready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
		end else if (cfg_wr_en) begin
			start_byte_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			byte_valid_s1 <= 1'b1;
		end else if (step) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	sfrc_parser #(
		.MAX_FRAME (MAX_FRAME)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte    (byte_s1),
		.start_byte (start_byte_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Result register: loads on a result word, clears once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_status    = out_q.status;
	assign frame_address   = out_q.address;
	assign frame_command   = out_q.command;
	assign frame_data_word = out_q.data_word;
	assign frame_count     = out_q.count;

	// a word waiting in the input stage is not lost or changed while stalled
	`SFRC_ASSERT_NEXT(a_s1_hold, clk, arst_n, byte_valid_s1 && !advance,
		byte_valid_s1 && $stable(byte_s1))

	// too-long and too-short results carry no frame contents
	`SFRC_ASSERT_IMPL(a_abort_zero, clk, arst_n,
		out_valid_q && (out_q.status == ST_TOO_LONG || out_q.status == ST_TOO_SHORT),
		out_q.address == '0 && out_q.command == '0 && out_q.data_word == '0)

	// a checked frame always had a count in range
	`SFRC_ASSERT_IMPL(a_count_range, clk, arst_n,
		out_valid_q && (out_q.status == ST_OK || out_q.status == ST_BAD_SUM),
		out_q.count >= 8'd2 && out_q.count < BYTE_W'(MAX_FRAME))

	// a too-long result reports a count at or above the limit
	`SFRC_ASSERT_IMPL(a_too_long_count, clk, arst_n,
		out_valid_q && out_q.status == ST_TOO_LONG,
		out_q.count >= BYTE_W'(MAX_FRAME))

endmodule

`default_nettype wire
